### rtl/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types, codes and color arithmetic for the LED ring controller.
// ----------------------------------------------------------------------------
package lrc_pkg;

  // default ring size
  localparam int NUM_LEDS_DEF = 12;

  // input word kinds
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;
  localparam logic [1:0] KIND_ENC  = 2'd3;

  // command operations (upper nibble)
  localparam logic [3:0] OP_MODE   = 4'h1;
  localparam logic [3:0] OP_BRIGHT = 4'h2;
  localparam logic [3:0] OP_POS    = 4'h4;
  localparam logic [3:0] OP_LED    = 4'h8;

  // mode values (lower nibble)
  localparam logic [3:0] MODE_FIXED = 4'h1;
  localparam logic [3:0] MODE_GAUGE = 4'h2;

  // result kinds
  localparam logic RES_READ  = 1'b0;
  localparam logic RES_PIXEL = 1'b1;

  // message length that selects a full RGB set
  localparam logic [2:0] LEN_RGB = 3'd4;

  localparam logic [7:0] BRIGHT_RST = 8'd50;

  // gauge colors before brightness scaling
  localparam logic [7:0] AMBER_R = 8'd75;
  localparam logic [7:0] AMBER_G = 8'd50;
  localparam logic [7:0] GREEN_G = 8'd200;

  // color wheel segment bounds
  localparam logic [7:0] WHEEL_ONE = 8'd85;
  localparam logic [7:0] WHEEL_TWO = 8'd170;
  localparam logic [7:0] FULL      = 8'd255;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic       shift;
    logic       clear;
    logic       wr_en;
    logic [3:0] wr_idx;
  } cell_ctl_t;

  // exact x / 255 for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] sum;
    sum = x + {8'd0, x[15:8]} + 16'd1;
    return sum[15:8];
  endfunction

  // color wheel, not scaled
  function automatic rgb_t wheel(input logic [7:0] p);
    rgb_t       c;
    logic [7:0] q;
    logic [9:0] t3;
    logic [7:0] t;
    if (p < WHEEL_ONE) q = p;
    else if (p < WHEEL_TWO) q = p - WHEEL_ONE;
    else q = p - WHEEL_TWO;
    t3 = {2'b00, q} * 10'd3;
    t  = t3[7:0];
    if (p < WHEEL_ONE) begin
      c.r = t;
      c.g = FULL - t;
      c.b = 8'd0;
    end else if (p < WHEEL_TWO) begin
      c.r = FULL - t;
      c.g = 8'd0;
      c.b = t;
    end else begin
      c.r = 8'd0;
      c.g = t;
      c.b = FULL - t;
    end
    return c;
  endfunction

  // one channel: (target + 3*shown) / 4
  function automatic logic [7:0] smooth_ch(input logic [7:0] t, input logic [7:0] s);
    logic [9:0] sum;
    sum = {2'b00, t} + {2'b00, s} + {1'b0, s, 1'b0};
    return sum[9:2];
  endfunction

  function automatic rgb_t smooth(input rgb_t t, input rgb_t s);
    rgb_t c;
    c.r = smooth_ch(t.r, s.r);
    c.g = smooth_ch(t.g, s.g);
    c.b = smooth_ch(t.b, s.b);
    return c;
  endfunction

endpackage

### rtl/lrc_cell.sv
// ----------------------------------------------------------------------------
// lrc_cell
// One LED of the ring: target and shown color, shifted to its neighbor.
// ----------------------------------------------------------------------------
module lrc_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  lrc_pkg::cell_ctl_t ctl,
  input  lrc_pkg::rgb_t     wr_data,
  input  lrc_pkg::rgb_t     in_tgt,
  input  lrc_pkg::rgb_t     in_shown,
  output lrc_pkg::rgb_t     tgt,
  output lrc_pkg::rgb_t     shown
);
  import lrc_pkg::*;

  logic hit;

  assign hit = ctl.wr_en && (ctl.wr_idx == 4'(IDX));

  // shift has priority; writes and clears only happen while the ring is parked
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt   <= '0;
      shown <= '0;
    end else if (ctl.shift) begin
      tgt   <= in_tgt;
      shown <= in_shown;
    end else if (ctl.clear) begin
      tgt <= '0;
    end else if (hit) begin
      tgt <= wr_data;
    end
  end

endmodule

### rtl/lrc_scale.sv
// ----------------------------------------------------------------------------
// lrc_scale
// Brightness scaler: three 8x8 products registered, then divided by 255.
// ----------------------------------------------------------------------------
module lrc_scale (
  input  logic          clk,
  input  logic [7:0]    level,
  input  lrc_pkg::rgb_t op,
  output lrc_pkg::rgb_t res
);
  import lrc_pkg::*;

  logic [15:0] prod_r;
  logic [15:0] prod_g;
  logic [15:0] prod_b;

  // product stage
  always_ff @(posedge clk) begin
    prod_r <= 16'(level) * 16'(op.r);
    prod_g <= 16'(level) * 16'(op.g);
    prod_b <= 16'(level) * 16'(op.b);
  end

  // divide by 255 on the registered products
  assign res.r = div255(prod_r);
  assign res.g = div255(prod_g);
  assign res.b = div255(prod_b);

endmodule

### rtl/led_ring_command_controller.sv
// ----------------------------------------------------------------------------
// led_ring_command_controller
// Twelve-LED ring controller: commands, position reads, gauge render and
// smoothed pixel output through a rotating chain of LED cells.
// ----------------------------------------------------------------------------
//
//  channel | signals                               | moves
//  --------+---------------------------------------+------------------------------
//  in      | in_valid / in_stall                   | kind, command args, position
//  out     | out_valid / out_stall                 | read data or one pixel
//
//  Command, encoder word: in S_IDLE; RGB LED set: S_SCALE (scaler product stage).
//  Read: S_READ loads the output register. Frame tick: S_TICK gives a pixel per LED,
//  after S_PREP in auto mode (gauge color scaling); chain rotates one cell per pixel.
//  Reset (rst, synchronous) clears all cells, sets brightness 50 and auto mode.
//  A stall on out holds the pixel and freezes the chain; in_stall is high while busy.
//
module led_ring_command_controller #(
  parameter int NUM_LEDS = lrc_pkg::NUM_LEDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        kind,
  input  logic [7:0]        cmd_byte,
  input  logic [7:0]        arg_one,
  input  logic [7:0]        arg_two,
  input  logic [7:0]        arg_three,
  input  logic [2:0]        msg_length,
  input  logic signed [7:0] new_position,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              result_kind,
  output logic [7:0]        read_data,
  output logic [3:0]        led_index,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue,
  output logic              last
);
  import lrc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_TICK  = 3'd4;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic [7:0]  brightness;
  logic        manual;
  logic [7:0]  position;
  logic [5:0]  ticks;
  logic [3:0]  led_sel;
  logic [3:0]  cnt;
  rgb_t        gauge_amber;
  rgb_t        gauge_green;

  logic        in_acc;
  logic        out_free;
  logic [3:0]  op;
  logic [3:0]  nib;
  logic        idx_ok;
  logic        cnt_last;
  logic [7:0]  pos_clamp;
  logic [12:0] mul3;
  logic [5:0]  ticks_calc;
  logic [4:0]  half;
  logic        amber_hit;
  logic        green_hit;
  rgb_t        head_tgt;
  rgb_t        head_shown;
  rgb_t        sc_op;
  rgb_t        sc_res;
  rgb_t        wr_data;
  cell_ctl_t   ctl;

  rgb_t        cell_tgt   [NUM_LEDS];
  rgb_t        cell_shown [NUM_LEDS];

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign op       = cmd_byte[7:4];
  assign nib      = cmd_byte[3:0];
  assign idx_ok   = ({1'b0, nib} < 5'(NUM_LEDS));
  assign cnt_last = (cnt == 4'(NUM_LEDS - 1));

  // gauge geometry: clamp negative position, ticks = position / 3
  assign pos_clamp  = position[7] ? 8'd0 : position;
  assign mul3       = {6'd0, pos_clamp[6:0]} * 13'd43;
  assign ticks_calc = mul3[12:7];
  assign half       = ticks[5:1];
  assign amber_hit  = ticks[0] && ({2'b00, cnt} == ({1'b0, half} + 6'd1));
  assign green_hit  = ({1'b0, cnt} <= half);

  // head of the ring: render target in auto mode, then smooth
  always_comb begin
    if (manual) head_tgt = cell_tgt[0];
    else if (amber_hit) head_tgt = gauge_amber;
    else if (green_hit) head_tgt = gauge_green;
    else head_tgt = '0;
  end

  assign head_shown = smooth(head_tgt, cell_shown[0]);

  // scaler operands: gauge colors on a tick, the RGB args otherwise
  always_comb begin
    if (kind == KIND_TICK) begin
      sc_op.r = AMBER_R;
      sc_op.g = GREEN_G;
      sc_op.b = AMBER_G;
    end else begin
      sc_op.r = arg_one;
      sc_op.g = arg_two;
      sc_op.b = arg_three;
    end
  end

  lrc_scale u_scale (
    .clk   (clk),
    .level (brightness),
    .op    (sc_op),
    .res   (sc_res)
  );

  // chain control
  always_comb begin
    ctl.shift  = (state == S_TICK) && out_free;
    ctl.clear  = in_acc && (kind == KIND_CMD) && (op == OP_MODE) && (nib == MODE_FIXED);
    ctl.wr_en  = (state == S_SCALE) ||
                 (in_acc && (kind == KIND_CMD) && (op == OP_LED) && idx_ok &&
                  (msg_length != LEN_RGB));
    ctl.wr_idx = (state == S_SCALE) ? led_sel : nib;
  end

  assign wr_data = (state == S_SCALE) ? sc_res : wheel(arg_one);

  // ring of cells; the last one takes the processed head
  for (genvar gi = 0; gi < NUM_LEDS; gi++) begin : g_ring
    if (gi == NUM_LEDS - 1) begin : g_tail
      lrc_cell #(.IDX(gi)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .wr_data  (wr_data),
        .in_tgt   (head_tgt),
        .in_shown (head_shown),
        .tgt      (cell_tgt[gi]),
        .shown    (cell_shown[gi])
      );
    end else begin : g_body
      lrc_cell #(.IDX(gi)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .wr_data  (wr_data),
        .in_tgt   (cell_tgt[gi + 1]),
        .in_shown (cell_shown[gi + 1]),
        .tgt      (cell_tgt[gi]),
        .shown    (cell_shown[gi])
      );
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          unique case (kind)
            KIND_CMD: begin
              if ((op == OP_LED) && idx_ok && (msg_length == LEN_RGB)) state_next = S_SCALE;
            end
            KIND_READ: state_next = S_READ;
            KIND_TICK: state_next = manual ? S_TICK : S_PREP;
            KIND_ENC:  state_next = S_IDLE;
          endcase
        end
      end
      S_SCALE: state_next = S_IDLE;
      S_READ: begin
        if (out_free) state_next = S_IDLE;
      end
      S_PREP: state_next = S_TICK;
      S_TICK: begin
        if (out_free && cnt_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      brightness <= BRIGHT_RST;
      manual     <= 1'b0;
      position   <= 8'd0;
      cnt        <= 4'd0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        unique case (kind)
          KIND_CMD: begin
            unique case (op)
              OP_MODE: begin
                if (nib == MODE_FIXED) manual <= 1'b1;
                else if (nib == MODE_GAUGE) manual <= 1'b0;
              end
              OP_BRIGHT: brightness <= arg_one;
              OP_POS:    position   <= arg_one;
              default: ;
            endcase
          end
          KIND_ENC:  position <= new_position;
          KIND_TICK: begin
            if (!manual) position <= pos_clamp;
          end
          KIND_READ: ;
        endcase
      end
      if ((state == S_TICK) && out_free) cnt <= cnt_last ? 4'd0 : cnt + 4'd1;
      if (out_free) out_valid <= (state == S_READ) || (state == S_TICK);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      led_sel <= nib;
      if (kind == KIND_TICK) ticks <= ticks_calc;
    end
    if (state == S_PREP) begin
      gauge_amber <= '{r: sc_res.r, g: sc_res.b, b: 8'd0};
      gauge_green <= '{r: 8'd0, g: sc_res.g, b: 8'd0};
    end
    if (out_free && (state == S_READ)) begin
      result_kind <= RES_READ;
      read_data   <= position;
      led_index   <= 4'd0;
      red         <= 8'd0;
      green       <= 8'd0;
      blue        <= 8'd0;
      last        <= 1'b1;
    end else if (out_free && (state == S_TICK)) begin
      result_kind <= RES_PIXEL;
      read_data   <= 8'd0;
      led_index   <= cnt;
      red         <= head_shown.r;
      green       <= head_shown.g;
      blue        <= head_shown.b;
      last        <= cnt_last;
    end
  end

endmodule

### rtl/lrc_check.sv
// ----------------------------------------------------------------------------
// lrc_check
// Port-level checks for the LED ring controller, bound to the top level.
// ----------------------------------------------------------------------------
module lrc_check #(
  parameter int NUM_LEDS = lrc_pkg::NUM_LEDS_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       result_kind,
  input logic [7:0] read_data,
  input logic [3:0] led_index,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic       last
);
  import lrc_pkg::*;

  // a stalled word stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // a read word is a single, last word with zero pixel fields
  a_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == RES_READ) |->
      last && (led_index == 4'd0) && (red == 8'd0) && (green == 8'd0) && (blue == 8'd0))
    else $error("malformed read word");

  // pixel index in range, last only on the final LED
  a_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == RES_PIXEL) |->
      (read_data == 8'd0) && (led_index < 4'(NUM_LEDS)) &&
      (last == (led_index == 4'(NUM_LEDS - 1))))
    else $error("malformed pixel word");

  // pixels of a frame follow back to back in index order
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && (result_kind == RES_PIXEL) && !last |=>
      out_valid && (result_kind == RES_PIXEL) && (led_index == $past(led_index) + 4'd1))
    else $error("pixel sequence broken");

endmodule

bind led_ring_command_controller lrc_check #(.NUM_LEDS(NUM_LEDS)) u_check (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .result_kind (result_kind),
  .read_data   (read_data),
  .led_index   (led_index),
  .red         (red),
  .green       (green),
  .blue        (blue),
  .last        (last)
);

### test/tb_led_ring_command_controller.sv
// ----------------------------------------------------------------------------
// tb_led_ring_command_controller
// Self-checking bench for the LED ring controller. A directed opening covers
// reset state, mode and brightness extremes, wheel segments, out-of-range LED
// indices, ignored opcodes and negative positions. A long random run with
// random gaps on both sides follows. A local ring model predicts every read
// and pixel word, and each output word is checked field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_led_ring_command_controller;
  import lrc_pkg::*;

  localparam int RING_SIZE   = NUM_LEDS_DEF;
  localparam int RANDOM_WORDS = 405;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [1:0]        kind;
    logic [7:0]        cmd;
    logic [7:0]        a1;
    logic [7:0]        a2;
    logic [7:0]        a3;
    logic [2:0]        len;
    logic signed [7:0] npos;
    bit                wait_drain;
  } ring_word_t;

  typedef struct {
    logic       kind;
    logic [7:0] data;
    logic [3:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
  } ring_out_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        kind = '0;
  logic [7:0]        cmd_byte = '0;
  logic [7:0]        arg_one = '0;
  logic [7:0]        arg_two = '0;
  logic [7:0]        arg_three = '0;
  logic [2:0]        msg_length = 3'd1;
  logic signed [7:0] new_position = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              result_kind;
  logic [7:0]        read_data;
  logic [3:0]        led_index;
  logic [7:0]        red;
  logic [7:0]        green;
  logic [7:0]        blue;
  logic              last;

  led_ring_command_controller dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .cmd_byte     (cmd_byte),
    .arg_one      (arg_one),
    .arg_two      (arg_two),
    .arg_three    (arg_three),
    .msg_length   (msg_length),
    .new_position (new_position),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .read_data    (read_data),
    .led_index    (led_index),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .last         (last)
  );

  // ring model state
  rgb_t       target_rgb [RING_SIZE];
  rgb_t       shown_rgb  [RING_SIZE];
  logic [7:0] bright_lvl;
  bit         manual_on;
  logic [7:0] ring_pos;

  ring_word_t stim_words [$];
  ring_out_t  due_outputs [$];
  ring_word_t cur_word;

  int errors;
  int words_sent;
  int results_seen;
  int send_gap;
  int hold_gap;
  int backlog_hold;
  bit backlog_done;
  int idle_cycles;
  int n_ticks, n_reads, n_cmds, n_enc, n_manual_ticks;

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  task automatic note_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [7:0] dim(input logic [7:0] v);
    return 8'((int'(bright_lvl) * int'(v)) / 255);
  endfunction

  function automatic rgb_t wheel_colour(input logic [7:0] w);
    int p;
    p = int'(w);
    if (p < 85) return {8'(p * 3), 8'(255 - p * 3), 8'd0};
    else if (p < 170) return {8'(255 - (p - 85) * 3), 8'd0, 8'((p - 85) * 3)};
    else return {8'd0, 8'((p - 170) * 3), 8'(255 - (p - 170) * 3)};
  endfunction

  function automatic logic [7:0] ease(input logic [7:0] t, input logic [7:0] s);
    return 8'((int'(t) + 3 * int'(s)) / 4);
  endfunction

  // advance the ring model by one accepted word, queue what it should emit
  task automatic predict_ring(input ring_word_t w);
    int        ticks;
    int        half;
    ring_out_t o;
    case (w.kind)
      KIND_CMD: begin
        n_cmds++;
        case (w.cmd[7:4])
          OP_MODE: begin
            if (w.cmd[3:0] == MODE_FIXED) begin
              foreach (target_rgb[i]) target_rgb[i] = '0;
              manual_on = 1'b1;
            end else if (w.cmd[3:0] == MODE_GAUGE) begin
              manual_on = 1'b0;
            end
          end
          OP_BRIGHT: bright_lvl = w.a1;
          OP_POS:    ring_pos = w.a1;
          OP_LED: begin
            if (int'(w.cmd[3:0]) < RING_SIZE) begin
              if (w.len == LEN_RGB)
                target_rgb[w.cmd[3:0]] = {dim(w.a1), dim(w.a2), dim(w.a3)};
              else
                target_rgb[w.cmd[3:0]] = wheel_colour(w.a1);
            end
          end
          default: ;
        endcase
      end
      KIND_READ: begin
        n_reads++;
        o = '{kind: RES_READ, data: ring_pos, idx: '0, r: '0, g: '0, b: '0, last: 1'b1};
        due_outputs.push_back(o);
      end
      KIND_ENC: begin
        n_enc++;
        ring_pos = w.npos;
      end
      default: begin
        n_ticks++;
        // gauge render in auto mode, negative position clamps to zero
        if (!manual_on) begin
          if (ring_pos[7]) ring_pos = '0;
          ticks = int'(ring_pos) / 3;
          half  = ticks / 2;
          for (int i = 0; i < RING_SIZE; i++) begin
            if (ticks[0] && i == half + 1)
              target_rgb[i] = {dim(AMBER_R), dim(AMBER_G), 8'd0};
            else if (i <= half)
              target_rgb[i] = {8'd0, dim(GREEN_G), 8'd0};
            else
              target_rgb[i] = '0;
          end
        end else begin
          n_manual_ticks++;
        end
        for (int i = 0; i < RING_SIZE; i++) begin
          shown_rgb[i].r = ease(target_rgb[i].r, shown_rgb[i].r);
          shown_rgb[i].g = ease(target_rgb[i].g, shown_rgb[i].g);
          shown_rgb[i].b = ease(target_rgb[i].b, shown_rgb[i].b);
          o = '{kind: RES_PIXEL, data: '0, idx: 4'(i), r: shown_rgb[i].r,
                g: shown_rgb[i].g, b: shown_rgb[i].b, last: (i == RING_SIZE - 1)};
          due_outputs.push_back(o);
        end
      end
    endcase
  endtask

  task automatic queue_word(input logic [1:0] k, input logic [7:0] c, input logic [7:0] a1,
                            input logic [7:0] a2, input logic [7:0] a3,
                            input logic [2:0] len, input logic signed [7:0] np);
    ring_word_t w;
    w = '{kind: k, cmd: c, a1: a1, a2: a2, a3: a3, len: len, npos: np, wait_drain: 1'b0};
    stim_words.push_back(w);
  endtask

  // input driver
  always @(posedge clk) begin
    bit fire;
    bit quiet;
    fire  = in_valid && !in_stall;
    quiet = ((words_sent / 40) % 4 == 3);
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        predict_ring(cur_word);
        words_sent++;
        send_gap = quiet ? 0 : $urandom_range(0, 4);
      end
      if (!in_valid || fire) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (stim_words.size() > 0 &&
                     !(stim_words[0].wait_drain && due_outputs.size() != 0)) begin
          cur_word = stim_words.pop_front();
          kind         <= cur_word.kind;
          cmd_byte     <= cur_word.cmd;
          arg_one      <= cur_word.a1;
          arg_two      <= cur_word.a2;
          arg_three    <= cur_word.a3;
          msg_length   <= cur_word.len;
          new_position <= cur_word.npos;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and receiver stall
  always @(posedge clk) begin
    ring_out_t want;
    bit        quiet;
    quiet = ((results_seen / 50) % 4 == 1);
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_outputs.size() == 0) begin
          note_error($sformatf("output word with nothing due (kind %0d idx %0d)",
                               result_kind, led_index));
        end else begin
          want = due_outputs.pop_front();
          if (result_kind !== want.kind)
            note_error($sformatf("result_kind got %0d want %0d", result_kind, want.kind));
          if (read_data !== want.data)
            note_error($sformatf("read_data got %0d want %0d", read_data, want.data));
          if (led_index !== want.idx)
            note_error($sformatf("led_index got %0d want %0d", led_index, want.idx));
          if (red !== want.r)
            note_error($sformatf("red[%0d] got %0d want %0d", want.idx, red, want.r));
          if (green !== want.g)
            note_error($sformatf("green[%0d] got %0d want %0d", want.idx, green, want.g));
          if (blue !== want.b)
            note_error($sformatf("blue[%0d] got %0d want %0d", want.idx, blue, want.b));
          if (last !== want.last)
            note_error($sformatf("last[%0d] got %0d want %0d", want.idx, last, want.last));
        end
        hold_gap = quiet ? 0 : $urandom_range(0, 4);
        // one long hold-off so the block backs up and stalls its input
        if (!backlog_done && results_seen >= 300) begin
          backlog_done = 1'b1;
          backlog_hold = 120;
        end
      end
      if (backlog_hold > 0) begin
        backlog_hold--;
        out_stall <= 1'b1;
      end else if (hold_gap > 0) begin
        hold_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: %0d words pending, %0d outputs still due",
               stim_words.size(), due_outputs.size());
      $display("FAIL led_ring_command_controller");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    ring_word_t w;
    int         sel;
    int         csel;
    logic [3:0] lo;

    foreach (target_rgb[i]) begin
      target_rgb[i] = '0;
      shown_rgb[i]  = '0;
    end
    bright_lvl = BRIGHT_RST;
    manual_on  = 1'b0;
    ring_pos   = '0;

    // directed opening
    queue_word(KIND_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 8'sd0);
    queue_word(KIND_READ, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 8'sd0);
    queue_word(KIND_ENC,  8'h00, 8'h00, 8'h00, 8'h00, 3'd1, -8'sd128);
    queue_word(KIND_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 8'sd0);
    queue_word(KIND_READ, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 8'sd0);
    queue_word(KIND_CMD,  {OP_BRIGHT, 4'hF}, 8'hFF, 8'h00, 8'h00, 3'd1, 8'sd0);
    queue_word(KIND_ENC,  8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 8'sd127);
    queue_word(KIND_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 8'sd0);
    queue_word(KIND_CMD,  {OP_POS, 4'h0}, 8'h80, 8'h00, 8'h00, 3'd2, 8'sd0);
    queue_word(KIND_READ, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 8'sd0);
    queue_word(KIND_CMD,  {OP_MODE, MODE_FIXED}, 8'h00, 8'h00, 8'h00, 3'd1, 8'sd0);
    queue_word(KIND_CMD,  {OP_LED, 4'h0}, 8'hFF, 8'hFF, 8'hFF, LEN_RGB, 8'sd0);
    queue_word(KIND_CMD,  {OP_LED, 4'hB}, 8'hFF, 8'h00, 8'h00, 3'd1, 8'sd0);
    queue_word(KIND_CMD,  {OP_LED, 4'h5}, 8'd85, 8'h00, 8'h00, 3'd2, 8'sd0);
    queue_word(KIND_CMD,  {OP_LED, 4'h6}, 8'd170, 8'h00, 8'h00, 3'd3, 8'sd0);
    queue_word(KIND_CMD,  {OP_LED, 4'hC}, 8'hFF, 8'hFF, 8'hFF, LEN_RGB, 8'sd0);
    queue_word(KIND_CMD,  {OP_LED, 4'hF}, 8'd10, 8'h00, 8'h00, 3'd1, 8'sd0);
    queue_word(KIND_CMD,  {OP_MODE, 4'h3}, 8'h00, 8'h00, 8'h00, 3'd1, 8'sd0);
    queue_word(KIND_CMD,  8'h30, 8'hFF, 8'hFF, 8'hFF, 3'd4, 8'sd0);
    queue_word(KIND_CMD,  8'hF0, 8'hFF, 8'hFF, 8'hFF, 3'd4, 8'sd0);
    queue_word(KIND_CMD,  {OP_BRIGHT, 4'h0}, 8'h00, 8'h00, 8'h00, 3'd1, 8'sd0);
    queue_word(KIND_CMD,  {OP_LED, 4'h1}, 8'hFF, 8'h80, 8'h01, LEN_RGB, 8'sd0);
    queue_word(KIND_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 8'sd0);
    queue_word(KIND_READ, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 8'sd0);
    queue_word(KIND_CMD,  {OP_MODE, MODE_GAUGE}, 8'h00, 8'h00, 8'h00, 3'd1, 8'sd0);

    // random part: mostly meaningful commands, some raw noise
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      w.cmd        = 8'($urandom);
      w.a1         = 8'($urandom);
      w.a2         = 8'($urandom);
      w.a3         = 8'($urandom);
      w.len        = 3'($urandom_range(1, 4));
      w.npos       = 8'($urandom);
      w.wait_drain = (n == 150 || n == 320);
      sel = $urandom_range(0, 99);
      if (sel < 25) w.kind = KIND_TICK;
      else if (sel < 40) w.kind = KIND_READ;
      else if (sel < 52) w.kind = KIND_ENC;
      else begin
        w.kind = KIND_CMD;
        csel = $urandom_range(0, 99);
        lo   = 4'($urandom);
        if (csel < 8) begin
          // raw byte, any opcode
        end else if (csel < 20) begin
          if ($urandom_range(0, 3) == 0) w.cmd = {OP_MODE, lo};
          else if ($urandom_range(0, 2) == 0) w.cmd = {OP_MODE, MODE_FIXED};
          else w.cmd = {OP_MODE, MODE_GAUGE};
        end else if (csel < 32) begin
          w.cmd = {OP_BRIGHT, lo};
          if ($urandom_range(0, 3) == 0) w.a1 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else if (csel < 44) begin
          w.cmd = {OP_POS, lo};
        end else begin
          if ($urandom_range(0, 7) != 0) lo = 4'($urandom_range(0, RING_SIZE - 1));
          w.cmd = {OP_LED, lo};
        end
      end
      stim_words.push_back(w);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (stim_words.size() > 0 || in_valid) @(posedge clk);
    while (due_outputs.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d commands, %0d encoder updates, %0d reads", words_sent,
             n_cmds, n_enc, n_reads);
    $display("%0d frame ticks (%0d in manual mode), %0d output words checked", n_ticks,
             n_manual_ticks, results_seen);
    if (errors == 0) begin
      $display("PASS led_ring_command_controller");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL led_ring_command_controller");
    end
    $finish;
  end

endmodule
